### hw/rtl/msq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg
// Shared constants and types for the marching-squares cell extractor.
// ----------------------------------------------------------------------------
package msq_pkg;
    localparam int MAX_COLS_DEF    = 1024;
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int PPR_W   = 11;
    localparam int CSIZE_W = 7;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 15;
    localparam int KIND_W  = 3;
    localparam int MASK_W  = 4;
    localparam int CFG_W   = 11;

    localparam logic [0:0] REG_PPR   = 1'b0;
    localparam logic [0:0] REG_CSIZE = 1'b1;

    localparam logic [KIND_W-1:0] K_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] K_SW    = 3'd1;
    localparam logic [KIND_W-1:0] K_NW    = 3'd2;
    localparam logic [KIND_W-1:0] K_VERT  = 3'd3;
    localparam logic [KIND_W-1:0] K_NE    = 3'd4;
    localparam logic [KIND_W-1:0] K_CROSS = 3'd5;
    localparam logic [KIND_W-1:0] K_HORIZ = 3'd6;
    localparam logic [KIND_W-1:0] K_SE    = 3'd7;

    // divider request from the sequencer
    typedef struct packed {
        logic        start;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
    } t_div_stat;
endpackage

### hw/rtl/msq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_div
// Interpolation unit: floor(size * |a| * 2^F / (|a|+|b|)), one quotient bit
// per cycle after a registered multiply. Zero denominator gives zero.
// ----------------------------------------------------------------------------
module msq_div #(
    parameter int FRAC_BITS = msq_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  msq_pkg::t_div_req      i_req,
    input  logic [msq_pkg::CSIZE_W-1:0] i_csize,
    output msq_pkg::t_div_stat     o_stat,
    output logic [msq_pkg::COORD_W-1:0] o_quot
);
    import msq_pkg::*;

    // numerator = size*|a|*2^F, result < size*2^F+1 so QW bits suffice
    localparam int QW  = CSIZE_W + FRAC_BITS + 1;
    localparam int NW  = 33 + CSIZE_W + FRAC_BITS;
    localparam int CW  = $clog2(QW);

    logic [1:0]        r_st, n_st;
    localparam logic [1:0] S_IDLE = 2'd0, S_MUL = 2'd1, S_RUN = 2'd2, S_DONE = 2'd3;
    logic [32:0]       r_den;
    logic [32:0]       r_ma;
    logic [QW-1:0]     r_num;
    logic [33:0]       r_rem;
    logic [QW-1:0]     r_q;
    logic [CW-1:0]     r_cnt;
    logic [33:0]       w_trial;
    logic [NW-1:0]     w_prod;

    assign w_prod  = NW'({{(NW-33){1'b0}}, r_ma} * NW'(i_csize)) << FRAC_BITS;
    assign w_trial = {r_rem[32:0], r_num[r_cnt]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        unique case (r_st)
            S_IDLE: begin
                r_den <= {1'b0, i_req.mag_a} + {1'b0, i_req.mag_b};
                r_ma  <= {1'b0, i_req.mag_a};
            end
            S_MUL: begin
                // bits above the quotient window are already below den
                r_num <= w_prod[QW-1:0];
                r_rem <= 34'(w_prod >> QW);
                r_q   <= '0;
                r_cnt <= CW'(QW - 1);
            end
            S_RUN: begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_req.start) n_st = S_MUL;
            S_MUL:  n_st = S_RUN;
            S_RUN:  if (r_cnt == '0) n_st = S_DONE;
            default: n_st = S_IDLE;
        endcase
    end

    // den==0 only when both corners are zero
    assign o_stat.busy = (r_st != S_IDLE);
    assign o_stat.done = (r_st == S_DONE);
    assign o_quot = (r_den == '0) ? '0 : COORD_W'(r_q);
endmodule

### hw/rtl/msq_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_line
// Line store holding the previous row, one sample per column.
// ----------------------------------------------------------------------------
module msq_line #(
    parameter int MAX_COLS    = msq_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = msq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(MAX_COLS)-1:0] i_waddr,
    input  logic [SAMPLE_BITS-1:0]      i_wdata,
    input  logic [$clog2(MAX_COLS)-1:0] i_raddr,
    output logic [SAMPLE_BITS-1:0]      o_rdata
);
    import msq_pkg::*;
    logic [SAMPLE_BITS-1:0] r_mem [MAX_COLS];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/marching_squares_cell_extract_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_squares_cell_extract_top
// Zero-isoline marching-squares cell extractor over a raster sample stream.
// ----------------------------------------------------------------------------
// Usage: samples enter on i_valid/o_stall in raster order, i_frame_start on the
// first sample of a grid. Every sample past row 0 and column 0 completes a cell
// and produces one transfer on o_valid/i_stall carrying the corner mask, the
// crossing kind and up to two segments.
// Throughput: one sample at a time. A sample that completes no cell passes
// through accept, line read and evaluate. A cell adds one interpolation per
// crossed wall (0, 2 or 4) on the shared bit-serial divider (start, multiply,
// QW quotient bits, done), QW = 7+FRAC_BITS+1 (16 at defaults), and then an
// output step that holds until the result is taken.
// The previous row sits in a single-port-read memory that is read in the cycle
// before evaluation. Reset clears counters and left/north-west holds and sets
// the config registers to 64 and 10; the line store is not cleared. While
// i_stall is high the result holds and no new sample is taken.
// Config writes only when idle. The block itself does not enforce this.
// ----------------------------------------------------------------------------
module marching_squares_cell_extract_top #(
    parameter int MAX_COLS    = msq_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS    = msq_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = msq_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = msq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [msq_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_frame_start,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [msq_pkg::IDX_W-1:0]         o_cell_col,
    output logic [msq_pkg::IDX_W-1:0]         o_cell_row,
    output logic [msq_pkg::KIND_W-1:0]        o_cell_kind,
    output logic [msq_pkg::MASK_W-1:0]        o_corner_mask,
    output logic [msq_pkg::COORD_W-1:0]       o_first_x0,
    output logic [msq_pkg::COORD_W-1:0]       o_first_y0,
    output logic [msq_pkg::COORD_W-1:0]       o_first_x1,
    output logic [msq_pkg::COORD_W-1:0]       o_first_y1,
    output logic [msq_pkg::COORD_W-1:0]       o_second_x0,
    output logic [msq_pkg::COORD_W-1:0]       o_second_y0,
    output logic [msq_pkg::COORD_W-1:0]       o_second_x1,
    output logic [msq_pkg::COORD_W-1:0]       o_second_y1
);
    import msq_pkg::*;

    localparam int AW = $clog2(MAX_COLS);
    localparam int CNTW = IDX_W + 2;
    // row wrap limit: min(MAX_ROWS, 1024)
    localparam int ROW_LIM = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EVAL = 3'd2,
                           S_DIV = 3'd3, S_WAIT = 3'd4, S_OUT = 3'd5;

    logic [2:0]              r_st, n_st;
    logic [PPR_W-1:0]        r_ppr;
    logic [CSIZE_W-1:0]      r_csize;
    logic [CNTW-1:0]         r_col, r_row;
    logic signed [SAMPLE_BITS-1:0] r_left, r_nw, r_s;
    // cell corners held for the divider: se=r_s, ne=r_ne, nw=r_nwc, sw=r_sw
    logic signed [SAMPLE_BITS-1:0] r_ne, r_nwc, r_sw;
    logic [IDX_W-1:0]        r_ocol, r_orow;
    logic [KIND_W-1:0]       r_kind;
    logic [MASK_W-1:0]       r_mask;
    logic [COORD_W-1:0]      r_ps, r_pw, r_pn, r_pe;
    logic [3:0]              r_todo;    // bit0 S, 1 W, 2 N, 3 E
    logic [1:0]              r_wall;
    logic                    r_cell;

    logic signed [SAMPLE_BITS-1:0] w_above;
    logic [PPR_W-1:0]        w_ppr;
    logic [CNTW-1:0]         w_col, w_row;
    logic                    w_acc;
    logic [MASK_W-1:0]       w_mask;
    logic [KIND_W-1:0]       w_kind;
    logic [3:0]              w_need;
    t_div_req                w_req;
    t_div_stat               w_dst;
    logic [COORD_W-1:0]      w_quot;
    logic signed [SAMPLE_BITS-1:0] w_a, w_b;
    logic [COORD_W-1:0]      w_e;
    logic [1:0]              w_next;

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE);
    assign w_ppr   = (r_ppr < PPR_W'(2)) ? PPR_W'(2) :
                     (int'(r_ppr) > MAX_COLS) ? PPR_W'(MAX_COLS) : r_ppr;
    assign w_col   = i_frame_start ? '0 : r_col;
    assign w_row   = i_frame_start ? '0 : r_row;

    msq_line #(.MAX_COLS(MAX_COLS), .SAMPLE_BITS(SAMPLE_BITS)) u_line (
        .i_clk  (i_clk),
        .i_we   (r_st == S_EVAL),
        .i_waddr(r_col[AW-1:0]),
        .i_wdata(r_s),
        .i_raddr(r_col[AW-1:0]),
        .o_rdata(w_above)
    );

    assign w_mask = {r_s > 0, w_above > 0, r_nw > 0, r_left > 0};
    assign w_kind = w_mask[3] ? KIND_W'(4'd15 - w_mask) : w_mask[2:0];
    always_comb begin
        unique case (w_kind)
            K_SW:    w_need = 4'b0011;
            K_NW:    w_need = 4'b0110;
            K_VERT:  w_need = 4'b0101;
            K_NE:    w_need = 4'b1100;
            K_CROSS: w_need = 4'b1111;
            K_HORIZ: w_need = 4'b1010;
            K_SE:    w_need = 4'b1001;
            default: w_need = 4'b0000;
        endcase
    end

    // the divider latches the magnitudes on its start cycle, so select by w_next
    always_comb begin
        unique case (w_next)
            2'd0: begin w_a = r_sw;  w_b = r_s;  end
            2'd1: begin w_a = r_nwc; w_b = r_sw; end
            2'd2: begin w_a = r_nwc; w_b = r_ne; end
            default: begin w_a = r_ne; w_b = r_s; end
        endcase
    end
    function automatic logic [31:0] f_mag(input logic signed [SAMPLE_BITS-1:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return w[32] ? 32'(-w) : 32'(w);
    endfunction
    assign w_req.start = (r_st == S_DIV);
    assign w_req.mag_a = f_mag(w_a);
    assign w_req.mag_b = f_mag(w_b);

    msq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_csize(r_csize),
        .o_stat (w_dst),
        .o_quot (w_quot)
    );

    always_comb begin
        w_next = 2'd0;
        priority if (r_todo[0]) w_next = 2'd0;
        else if (r_todo[1])     w_next = 2'd1;
        else if (r_todo[2])     w_next = 2'd2;
        else                    w_next = 2'd3;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (w_acc) n_st = S_READ;
            S_READ: n_st = S_EVAL;
            S_EVAL: n_st = !r_cell ? S_IDLE : (w_need == '0 ? S_OUT : S_DIV);
            S_DIV:  n_st = S_WAIT;
            S_WAIT: if (w_dst.done) n_st = (r_todo == '0) ? S_OUT : S_DIV;
            S_OUT:  if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_ppr   <= PPR_W'(64);
            r_csize <= CSIZE_W'(10);
            r_col   <= '0;
            r_row   <= '0;
            r_left  <= '0;
            r_nw    <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PPR:   r_ppr   <= i_cfg_data;
                    REG_CSIZE: r_csize <= i_cfg_data[CSIZE_W-1:0];
                endcase
            end
            if (w_acc) begin
                r_s    <= i_sample;
                r_col  <= w_col;
                r_row  <= w_row;
                r_cell <= (w_col != '0) && (w_row != '0);
            end
            if (r_st == S_EVAL) begin
                r_ne   <= w_above;
                r_nwc  <= r_nw;
                r_sw   <= r_left;
                r_mask <= w_mask;
                r_kind <= w_kind;
                r_todo <= w_need;
                r_ps <= '0; r_pw <= '0; r_pn <= '0; r_pe <= '0;
                r_ocol <= IDX_W'(r_col - 1'b1);
                r_orow <= IDX_W'(r_row - 1'b1);
                r_nw   <= w_above;
                r_left <= r_s;
                if (CNTW'(r_col + 1'b1) >= CNTW'(w_ppr)) begin
                    r_col <= '0;
                    r_row <= (CNTW'(r_row + 1'b1) >= CNTW'(ROW_LIM)) ? '0 :
                             CNTW'(r_row + 1'b1);
                end else begin
                    r_col <= CNTW'(r_col + 1'b1);
                end
            end
            if (r_st == S_DIV) begin
                r_wall <= w_next;
                r_todo[w_next] <= 1'b0;
            end
            if (r_st == S_EVAL) r_wall <= 2'd0;
            if (r_st == S_WAIT && w_dst.done) begin
                unique case (r_wall)
                    2'd0: r_ps <= w_quot;
                    2'd1: r_pw <= w_quot;
                    2'd2: r_pn <= w_quot;
                    default: r_pe <= w_quot;
                endcase
            end
        end
    end

    assign w_e = COORD_W'({8'd0, r_csize} << FRAC_BITS);
    assign o_valid = (r_st == S_OUT);
    assign o_cell_col = r_ocol;
    assign o_cell_row = r_orow;
    assign o_cell_kind = r_kind;
    assign o_corner_mask = r_mask;
    always_comb begin
        o_first_x0 = '0; o_first_y0 = '0; o_first_x1 = '0; o_first_y1 = '0;
        o_second_x0 = '0; o_second_y0 = '0; o_second_x1 = '0; o_second_y1 = '0;
        unique case (r_kind)
            K_SW:    begin o_first_y0 = r_pw; o_first_x1 = r_ps; o_first_y1 = w_e; end
            K_NW:    begin o_first_y0 = r_pw; o_first_x1 = r_pn; end
            K_VERT:  begin o_first_x0 = r_pn; o_first_x1 = r_ps; o_first_y1 = w_e; end
            K_NE:    begin o_first_x0 = r_pn; o_first_x1 = w_e; o_first_y1 = r_pe; end
            K_CROSS: begin
                o_first_y0 = r_pw; o_first_x1 = r_ps; o_first_y1 = w_e;
                o_second_x0 = r_pn; o_second_x1 = w_e; o_second_y1 = r_pe;
            end
            K_HORIZ: begin o_first_y0 = r_pw; o_first_x1 = w_e; o_first_y1 = r_pe; end
            K_SE:    begin o_first_x0 = r_ps; o_first_y0 = w_e; o_first_x1 = w_e;
                           o_first_y1 = r_pe; end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_st == S_OUT && !w_dst.busy)
        else $error("result shown while divider busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(r_kind))
        else $error("stalled result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_kind == ((r_mask > 4'd7) ? KIND_W'(4'd15 - r_mask) : r_mask[2:0]))
        else $error("kind does not match mask");
endmodule
